// ===== src/tpc_pkg.sv =====
// Shared types, constants and a helper function for the triangle plane clipper.
// No dependencies; compile first.
`default_nettype none

package tpc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int Q_DEPTH        = 2;

  localparam longint unsigned NORMAL_Z_RST = 64'd65536;
  localparam longint unsigned PLANE_Z_RST  = 64'd6554;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_PLANE_X  = 3'd3,
    REG_PLANE_Y  = 3'd4,
    REG_PLANE_Z  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_SUM,
    BK_EMIT_A,
    BK_EMIT_B
  } bk_state_t;

  typedef enum logic [1:0] {
    OSEL_PASS,
    OSEL_ONE,
    OSEL_TWO_A,
    OSEL_TWO_B
  } osel_t;

  typedef struct packed {
    logic  pop;
    logic  capture;
    logic  div_en;
    logic  mul_en;
    logic  sum_en;
    logic  load;
    osel_t sel;
  } bk_ctrl_t;

  // Width of a plane distance: exact up to 128 bits, wraps beyond.
  function automatic int dist_width(input int c);
    return (2 * c + 3 > 128) ? 128 : 2 * c + 3;
  endfunction

endpackage

`default_nettype wire

// ===== src/tpc_if.sv =====
// Stream interfaces for triangles in and clipped triangles out.
// Depends on tpc_pkg.
`default_nettype none

interface tpc_in_if import tpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

interface tpc_out_if import tpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_v0_x, out_v0_y, out_v0_z;
  logic signed [COORD_BITS-1:0] out_v1_x, out_v1_y, out_v1_z;
  logic signed [COORD_BITS-1:0] out_v2_x, out_v2_y, out_v2_z;
  logic                         last_of_run;

  modport source (output valid, out_v0_x, out_v0_y, out_v0_z, out_v1_x, out_v1_y, out_v1_z,
                  out_v2_x, out_v2_y, out_v2_z, last_of_run, input ready);
  modport sink   (input valid, out_v0_x, out_v0_y, out_v0_z, out_v1_x, out_v1_y, out_v1_z,
                  out_v2_x, out_v2_y, out_v2_z, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/tpc_front.sv =====
// Front end: three-stage pipeline computing the plane distance of each vertex
// and the inside mask. Depends on tpc_pkg and tpc_in_if.
`default_nettype none

module tpc_front import tpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  tpc_in_if.sink                            in_ch,
  input  wire logic signed [COORD_BITS-1:0] nrm [3],
  input  wire logic signed [COORD_BITS-1:0] pnt [3],
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output logic [9*COORD_BITS+3*dist_width(COORD_BITS)+2:0] push_data
);

  localparam int C  = COORD_BITS;
  localparam int DW = dist_width(COORD_BITS);
  localparam int PW = 2 * C + 1;
  localparam int SW = 2 * C + 3;

  logic signed [C-1:0]  vin [3][3];
  logic                 en;
  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic signed [C-1:0]  s1_vert_r [3][3];
  logic signed [C-1:0]  s2_vert_r [3][3];
  logic signed [C-1:0]  s3_vert_r [3][3];
  logic signed [C:0]    s1_diff_r [3][3];
  logic signed [PW-1:0] s2_prod_r [3][3];
  logic signed [DW-1:0] s3_d_r [3];
  logic signed [SW-1:0] sum_full [3];

  assign vin[0][0] = in_ch.v0_x;
  assign vin[0][1] = in_ch.v0_y;
  assign vin[0][2] = in_ch.v0_z;
  assign vin[1][0] = in_ch.v1_x;
  assign vin[1][1] = in_ch.v1_y;
  assign vin[1][2] = in_ch.v1_z;
  assign vin[2][0] = in_ch.v2_x;
  assign vin[2][1] = in_ch.v2_y;
  assign vin[2][2] = in_ch.v2_z;

  // hold the whole pipe while the last stage waits on the queue
  assign en          = !(s3_v_r && !push_ready);
  assign in_ch.ready = en;
  assign push_valid  = s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_full[i] = SW'(s2_prod_r[i][0]) + SW'(s2_prod_r[i][1]) + SW'(s2_prod_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s1_vert_r[i][k] <= vin[i][k];
          s1_diff_r[i][k] <= (C+1)'(vin[i][k]) - (C+1)'(pnt[k]);
          s2_vert_r[i][k] <= s1_vert_r[i][k];
          s2_prod_r[i][k] <= PW'(nrm[k]) * PW'(s1_diff_r[i][k]);
          s3_vert_r[i][k] <= s2_vert_r[i][k];
        end
        s3_d_r[i] <= sum_full[i][DW-1:0];
      end
    end
  end

  always_comb begin
    push_data = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        push_data[(i*3+k)*C +: C] = s3_vert_r[i][k];
      end
      push_data[9*C + i*DW +: DW] = s3_d_r[i];
      push_data[9*C + 3*DW + i]   = ~s3_d_r[i][DW-1];
    end
  end

endmodule

`default_nettype wire

// ===== src/tpc_queue.sv =====
// Short register queue between front end and clip engine.
// Depends on tpc_pkg.
`default_nettype none

module tpc_queue import tpc_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  head_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data
);

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [AW-1:0]    wr_r, rd_r;
  logic [AW:0]      cnt_r;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != (AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == AW'(Q_DEPTH-1)) ? '0 : wr_r + 1'b1;
      if (do_pop)  rd_r <= (rd_r == AW'(Q_DEPTH-1)) ? '0 : rd_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== src/tpc_back.sv =====
// Clip engine: picks the crossing edges, runs two bit-serial dividers for t,
// scales the edges and emits up to two triangles. Depends on tpc_pkg, tpc_out_if.
`default_nettype none

module tpc_back import tpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  wire logic [9*COORD_BITS+3*dist_width(COORD_BITS)+2:0] head_data,
  output logic      pop,
  tpc_out_if.source out_ch
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW  = dist_width(COORD_BITS);
  localparam int RW  = DW + 2;
  localparam int MW  = C + F + 3;
  localparam int CW  = $clog2(F + 1);

  bk_state_t state_r, state_nxt;
  bk_ctrl_t  ctl;

  logic signed [C-1:0]  hv [3][3];
  logic signed [DW-1:0] hd [3];
  logic [2:0]           hins;
  logic [1:0]           i_s0, i_e0, i_s1, i_e1;
  logic                 h_two;
  logic                 out_free;

  logic signed [C-1:0]  s0_r [3], s1_r [3], x0_r [3], x1_r [3];
  logic signed [C:0]    diff0_r [3], diff1_r [3];
  logic signed [MW-1:0] prod0_r [3], prod1_r [3];
  logic [RW-1:0]        den0_r, den1_r, rem0_r, rem1_r;
  logic [F:0]           q0_r, q1_r;
  logic [CW-1:0]        cnt_r;
  logic                 two_r;
  logic                 ge0, ge1;
  logic [RW-1:0]        sub0, sub1;

  logic                 ov_valid_r;
  logic signed [C-1:0]  ov_r [3][3];
  logic                 olast_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        hv[i][k] = head_data[(i*3+k)*C +: C];
      end
      hd[i] = head_data[9*C + i*DW +: DW];
    end
    hins = head_data[9*C + 3*DW +: 3];
  end

  // crossing edges by inside mask; vertex order kept
  always_comb begin
    i_s0  = 2'd0;
    i_e0  = 2'd1;
    i_s1  = 2'd0;
    i_e1  = 2'd2;
    h_two = 1'b0;
    case (hins)
      3'b010: begin i_s0 = 2'd1; i_e0 = 2'd0; i_s1 = 2'd1; i_e1 = 2'd2; end
      3'b100: begin i_s0 = 2'd2; i_e0 = 2'd0; i_s1 = 2'd2; i_e1 = 2'd1; end
      3'b011: begin i_s0 = 2'd0; i_e0 = 2'd2; i_s1 = 2'd1; i_e1 = 2'd2; h_two = 1'b1; end
      3'b101: begin i_s0 = 2'd0; i_e0 = 2'd1; i_s1 = 2'd2; i_e1 = 2'd1; h_two = 1'b1; end
      3'b110: begin i_s0 = 2'd1; i_e0 = 2'd0; i_s1 = 2'd2; i_e1 = 2'd0; h_two = 1'b1; end
      default: begin end
    endcase
  end

  assign out_free = !ov_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_valid && hins != 3'b111 && hins != 3'b000) state_nxt = BK_DIV;
      end
      BK_DIV:    if (cnt_r == CW'(F)) state_nxt = BK_MUL;
      BK_MUL:    state_nxt = BK_SUM;
      BK_SUM:    state_nxt = BK_EMIT_A;
      BK_EMIT_A: if (out_free) state_nxt = two_r ? BK_EMIT_B : BK_IDLE;
      BK_EMIT_B: if (out_free) state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl = '{pop: 1'b0, capture: 1'b0, div_en: 1'b0, mul_en: 1'b0, sum_en: 1'b0,
            load: 1'b0, sel: OSEL_PASS};
    case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          if (hins == 3'b111) begin
            ctl.pop  = out_free;
            ctl.load = out_free;
          end else if (hins == 3'b000) begin
            ctl.pop = 1'b1;
          end else begin
            ctl.pop     = 1'b1;
            ctl.capture = 1'b1;
          end
        end
      end
      BK_DIV: ctl.div_en = 1'b1;
      BK_MUL: ctl.mul_en = 1'b1;
      BK_SUM: ctl.sum_en = 1'b1;
      BK_EMIT_A: begin
        ctl.load = out_free;
        ctl.sel  = two_r ? OSEL_TWO_A : OSEL_ONE;
      end
      BK_EMIT_B: begin
        ctl.load = out_free;
        ctl.sel  = OSEL_TWO_B;
      end
      default: begin end
    endcase
  end

  assign pop = ctl.pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      ov_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.load)          ov_valid_r <= 1'b1;
      else if (out_ch.ready) ov_valid_r <= 1'b0;
    end
  end

  assign ge0  = (rem0_r >= den0_r);
  assign ge1  = (rem1_r >= den1_r);
  assign sub0 = ge0 ? rem0_r - den0_r : rem0_r;
  assign sub1 = ge1 ? rem1_r - den1_r : rem1_r;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      for (int k = 0; k < 3; k++) begin
        s0_r[k]    <= hv[i_s0][k];
        s1_r[k]    <= hv[i_s1][k];
        diff0_r[k] <= (C+1)'(hv[i_e0][k]) - (C+1)'(hv[i_s0][k]);
        diff1_r[k] <= (C+1)'(hv[i_e1][k]) - (C+1)'(hv[i_s1][k]);
      end
      den0_r <= RW'(hd[i_s0]) - RW'(hd[i_e0]);
      den1_r <= RW'(hd[i_s1]) - RW'(hd[i_e1]);
      rem0_r <= RW'(hd[i_s0]);
      rem1_r <= RW'(hd[i_s1]);
      q0_r   <= '0;
      q1_r   <= '0;
      cnt_r  <= '0;
      two_r  <= h_two;
    end
    if (ctl.div_en) begin
      rem0_r <= {sub0[RW-2:0], 1'b0};
      rem1_r <= {sub1[RW-2:0], 1'b0};
      q0_r   <= {q0_r[F-1:0], ge0};
      q1_r   <= {q1_r[F-1:0], ge1};
      cnt_r  <= cnt_r + 1'b1;
    end
    if (ctl.mul_en) begin
      for (int k = 0; k < 3; k++) begin
        prod0_r[k] <= MW'(diff0_r[k]) * $signed(MW'(q0_r));
        prod1_r[k] <= MW'(diff1_r[k]) * $signed(MW'(q1_r));
      end
    end
    if (ctl.sum_en) begin
      for (int k = 0; k < 3; k++) begin
        x0_r[k] <= s0_r[k] + C'(prod0_r[k] >>> F);
        x1_r[k] <= s1_r[k] + C'(prod1_r[k] >>> F);
      end
    end
    if (ctl.load) begin
      case (ctl.sel)
        OSEL_PASS: begin
          ov_r    <= hv;
          olast_r <= 1'b1;
        end
        OSEL_ONE: begin
          ov_r[0] <= s0_r;
          ov_r[1] <= x0_r;
          ov_r[2] <= x1_r;
          olast_r <= 1'b1;
        end
        OSEL_TWO_A: begin
          ov_r[0] <= s0_r;
          ov_r[1] <= s1_r;
          ov_r[2] <= x0_r;
          olast_r <= 1'b0;
        end
        default: begin
          ov_r[0] <= s1_r;
          ov_r[1] <= x0_r;
          ov_r[2] <= x1_r;
          olast_r <= 1'b1;
        end
      endcase
    end
  end

  assign out_ch.valid       = ov_valid_r;
  assign out_ch.out_v0_x    = ov_r[0][0];
  assign out_ch.out_v0_y    = ov_r[0][1];
  assign out_ch.out_v0_z    = ov_r[0][2];
  assign out_ch.out_v1_x    = ov_r[1][0];
  assign out_ch.out_v1_y    = ov_r[1][1];
  assign out_ch.out_v1_z    = ov_r[1][2];
  assign out_ch.out_v2_x    = ov_r[2][0];
  assign out_ch.out_v2_y    = ov_r[2][1];
  assign out_ch.out_v2_z    = ov_r[2][2];
  assign out_ch.last_of_run = olast_r;

endmodule

`default_nettype wire

// ===== src/triangle_plane_clipper_core.sv =====
// A triangle wholly inside is loaded straight into the output register; a clipped
// one first runs through the t divider, the edge multiply and the sum.
// Throughput: one beat per cycle for pass-through or culled triangles while the
// clip engine is idle and the output is not stalled; a clip holds the engine in
// its bit-serial dividers, so the next triangle waits until the clip is emitted.
// Reset: rst_n synchronous active low; plane registers return to normal
// (0,0,1.0) and point (0,0,0.1), all queues and outputs empty.
`default_nettype none

module triangle_plane_clipper_core import tpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  tpc_in_if.sink                       in_ch,
  tpc_out_if.source                    out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  wire logic [COORD_BITS-1:0]   cfg_wdata
);

  localparam int EW = 9 * COORD_BITS + 3 * dist_width(COORD_BITS) + 3;

  logic signed [COORD_BITS-1:0] nrm_r [3];
  logic signed [COORD_BITS-1:0] pnt_r [3];
  logic                         push_valid, push_ready, head_valid, pop;
  logic [EW-1:0]                push_data, head_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= COORD_BITS'(NORMAL_Z_RST);
      pnt_r[0] <= '0;
      pnt_r[1] <= '0;
      pnt_r[2] <= COORD_BITS'(PLANE_Z_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NORMAL_X: nrm_r[0] <= cfg_wdata;
        REG_NORMAL_Y: nrm_r[1] <= cfg_wdata;
        REG_NORMAL_Z: nrm_r[2] <= cfg_wdata;
        REG_PLANE_X:  pnt_r[0] <= cfg_wdata;
        REG_PLANE_Y:  pnt_r[1] <= cfg_wdata;
        REG_PLANE_Z:  pnt_r[2] <= cfg_wdata;
        default: begin end
      endcase
    end
  end

  tpc_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .nrm        (nrm_r),
    .pnt        (pnt_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  tpc_queue #(.WIDTH(EW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  tpc_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ===== src/tpc_checker.sv =====
// Port-level checks on the clipper's result channel, bound to the top level.
// Depends on tpc_pkg and triangle_plane_clipper_core.
`default_nettype none

module tpc_checker import tpc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  out_last,
  input wire logic [COORD_BITS-1:0] out_v0_x,
  input wire logic [COORD_BITS-1:0] out_v2_z
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_last) && $stable(out_v0_x) && $stable(out_v2_z))
    else $error("result payload changed while stalled");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second triangle of a pair did not follow");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind triangle_plane_clipper_core tpc_checker #(.COORD_BITS(COORD_BITS)) u_tpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_of_run),
  .out_v0_x  (out_ch.out_v0_x),
  .out_v2_z  (out_ch.out_v2_z)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking bench for triangle_plane_clipper_core: directed rows, then random triangles
// over several plane settings, checked by row kind or a local fixed-point clipping predictor.
// Depends on tpc_pkg, tpc_if and the core.
`timescale 1ns / 100ps

module tb;
  import tpc_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int WATCH_LIMIT = 3000;
  localparam int SETTLE = 40;
  localparam int HOLD_OFF = 300;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [127:0] acc_t;
  typedef struct {
    coord_t p[3][3];
    logic   last;
  } tri_t;
  typedef enum int {ROW_PREDICT, ROW_PASS, ROW_CULL} row_kind_t;
  typedef struct {
    tri_t      t;
    row_kind_t kind;
  } row_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic [CW-1:0] cfg_wdata;

  tpc_in_if  #(.COORD_BITS(CW)) in_ch ();
  tpc_out_if #(.COORD_BITS(CW)) out_ch ();

  triangle_plane_clipper_core #(.COORD_BITS(CW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  coord_t plane_nrm[3];
  coord_t plane_pt[3];
  tri_t   tri_expected[$];
  int     err_count = 0;
  int     tri_sent = 0;
  int     tri_seen = 0;
  int     idle_cycles = 0;
  bit     hold_req = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  task automatic report(string msg);
    $display("tb: mismatch: %s", msg);
    err_count++;
  endtask

  // crossing from inside s to outside e, t truncated to Q0.FB
  function automatic void crossing(input coord_t s[3], input coord_t e[3],
                                   input acc_t ds, input acc_t de, output coord_t r[3]);
    acc_t den, tq, ws, we, step, sum;
    den = ds - de;
    tq = (ds <<< FB) / den;
    for (int k = 0; k < 3; k++) begin
      ws = s[k];
      we = e[k];
      step = (we - ws) * tq;
      sum = ws + (step >>> FB);
      r[k] = sum[CW-1:0];
    end
  endfunction

  function automatic tri_t make_tri(coord_t a[3], coord_t b[3], coord_t c[3], logic last);
    tri_t t;
    t.p[0] = a;
    t.p[1] = b;
    t.p[2] = c;
    t.last = last;
    return t;
  endfunction

  function automatic void clip_triangle(tri_t t);
    acc_t vdist[3], acc, n, v, p;
    int ins[3], outs[3];
    int ni, no;
    coord_t x0[3], x1[3];
    ni = 0;
    no = 0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        n = plane_nrm[k];
        v = t.p[i][k];
        p = plane_pt[k];
        acc = acc + n * (v - p);
      end
      vdist[i] = acc;
      if (acc >= 0) begin
        ins[ni] = i;
        ni = ni + 1;
      end else begin
        outs[no] = i;
        no = no + 1;
      end
    end
    case (ni)
      3: begin
        t.last = 1'b1;
        tri_expected.push_back(t);
      end
      1: begin
        crossing(t.p[ins[0]], t.p[outs[0]], vdist[ins[0]], vdist[outs[0]], x0);
        crossing(t.p[ins[0]], t.p[outs[1]], vdist[ins[0]], vdist[outs[1]], x1);
        tri_expected.push_back(make_tri(t.p[ins[0]], x0, x1, 1'b1));
      end
      2: begin
        crossing(t.p[ins[0]], t.p[outs[0]], vdist[ins[0]], vdist[outs[0]], x0);
        crossing(t.p[ins[1]], t.p[outs[0]], vdist[ins[1]], vdist[outs[0]], x1);
        tri_expected.push_back(make_tri(t.p[ins[0]], t.p[ins[1]], x0, 1'b0));
        tri_expected.push_back(make_tri(t.p[ins[1]], x0, x1, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, coord_t val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx <= REG_PLANE_Z) begin
      if (idx < REG_PLANE_X) plane_nrm[idx] = val;
      else plane_pt[idx - REG_PLANE_X] = val;
    end
  endtask

  // wait for every expected beat, then let culled work drain
  task automatic drain();
    while (tri_expected.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_plane(coord_t nx, coord_t ny, coord_t nz,
                           coord_t px, coord_t py, coord_t pz);
    drain();
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    write_reg(REG_PLANE_X, px);
    write_reg(REG_PLANE_Y, py);
    write_reg(REG_PLANE_Z, pz);
  endtask

  task automatic send_tri(tri_t t, row_kind_t kind);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z} = {t.p[0][0], t.p[0][1], t.p[0][2]};
    {in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} = {t.p[1][0], t.p[1][1], t.p[1][2]};
    {in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = {t.p[2][0], t.p[2][1], t.p[2][2]};
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    case (kind)
      ROW_PASS: begin
        t.last = 1'b1;
        tri_expected.push_back(t);
      end
      ROW_CULL: ;
      default: clip_triangle(t);
    endcase
    tri_sent++;
    @(negedge clk);
    // drop valid so the beat is not offered again; a back-to-back send raises it at once
    in_ch.valid = 1'b0;
  endtask

  function automatic coord_t rand_coord(bit wide);
    if (wide) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
  endfunction

  function automatic tri_t rand_tri(bit wide);
    tri_t t;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) t.p[i][k] = rand_coord(wide);
    t.last = 1'b0;
    return t;
  endfunction

  function automatic tri_t flat_tri(coord_t z0, coord_t z1, coord_t z2);
    tri_t t;
    t.p[0] = '{32'sh0001_0000, 32'sh0000_0000, z0};
    t.p[1] = '{32'sh0000_0000, 32'sh0001_0000, z1};
    t.p[2] = '{-32'sh0001_0000, -32'sh0001_0000, z2};
    t.last = 1'b0;
    return t;
  endfunction

  // out side: ready drawn per beat, with one long hold-off on request
  initial begin
    int w;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_req = 0;
      end
      w = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
      if (w > 0) begin
        out_ch.ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    tri_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.p[0] = '{out_ch.out_v0_x, out_ch.out_v0_y, out_ch.out_v0_z};
      got.p[1] = '{out_ch.out_v1_x, out_ch.out_v1_y, out_ch.out_v1_z};
      got.p[2] = '{out_ch.out_v2_x, out_ch.out_v2_y, out_ch.out_v2_z};
      got.last = out_ch.last_of_run;
      tri_seen++;
      if (tri_expected.size() == 0) begin
        report($sformatf("unexpected triangle beat %0d", tri_seen));
      end else begin
        want = tri_expected.pop_front();
        for (int i = 0; i < 3; i++)
          for (int k = 0; k < 3; k++)
            if (got.p[i][k] !== want.p[i][k])
              report($sformatf("beat %0d v%0d[%0d]: got %h want %h",
                               tri_seen, i, k, got.p[i][k], want.p[i][k]));
        if (got.last !== want.last)
          report($sformatf("beat %0d last_of_run: got %b want %b", tri_seen, got.last,
                           want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb: watchdog, no beat for %0d cycles", WATCH_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    coord_t mx, mn, z;
    mx = 32'sh7fff_ffff;
    mn = -32'sh7fff_ffff - 1;
    z = 32'sh0000_1999 + 1;
    plane_nrm = '{0, 0, 32'sh0001_0000};
    plane_pt = '{0, 0, z};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_NORMAL_X;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.v0_x, in_ch.v0_y, in_ch.v0_z, in_ch.v1_x, in_ch.v1_y, in_ch.v1_z,
     in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // reset plane is z >= 0.1 facing +z
    rows.push_back('{flat_tri(32'sh0002_0000, 32'sh0003_0000, 32'sh0004_0000), ROW_PASS});
    rows.push_back('{flat_tri(-32'sh0002_0000, 0, -32'sh0001_0000), ROW_CULL});
    rows.push_back('{flat_tri(z, z, z), ROW_PASS});
    rows.push_back('{flat_tri(mx, mx, mx), ROW_PASS});
    rows.push_back('{flat_tri(mn, mn, mn), ROW_CULL});
    rows.push_back('{flat_tri(z - 1, z - 1, z - 1), ROW_CULL});
    rows.push_back('{flat_tri(32'sh0001_0000, -32'sh0001_0000, -32'sh0002_0000),
                     ROW_PREDICT});
    rows.push_back('{flat_tri(-32'sh0001_0000, 32'sh0001_0000, -32'sh0002_0000),
                     ROW_PREDICT});
    rows.push_back('{flat_tri(-32'sh0001_0000, -32'sh0002_0000, 32'sh0001_0000),
                     ROW_PREDICT});
    rows.push_back('{flat_tri(32'sh0001_0000, 32'sh0002_0000, -32'sh0001_0000),
                     ROW_PREDICT});
    rows.push_back('{flat_tri(32'sh0001_0000, -32'sh0001_0000, 32'sh0002_0000),
                     ROW_PREDICT});
    rows.push_back('{flat_tri(-32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000),
                     ROW_PREDICT});
    rows.push_back('{flat_tri(z, mn, mn), ROW_PREDICT});
    rows.push_back('{flat_tri(mx, mx, mn), ROW_PREDICT});
    rows.push_back('{flat_tri(mx, mn, mn), ROW_PREDICT});
    rows.push_back('{flat_tri(z, z, z - 1), ROW_PREDICT});
    rows.push_back('{rand_tri(1), ROW_PREDICT});
    foreach (rows[r]) send_tri(rows[r].t, rows[r].kind);

    // unused indexes must leave the plane alone
    drain();
    write_reg(REG_SPARE_LO, mx);
    write_reg(REG_SPARE_HI, mn);
    for (int r = 0; r < 6; r++) send_tri(rand_tri(r[0]), ROW_PREDICT);

    // zero normal: everything passes
    set_plane(0, 0, 0, mx, mn, 0);
    rows.delete();
    rows.push_back('{flat_tri(mn, mn, mn), ROW_PASS});
    rows.push_back('{flat_tri(mx, mn, 0), ROW_PASS});
    foreach (rows[r]) send_tri(rows[r].t, rows[r].kind);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: set_plane(mx, mx, mx, mn, mn, mn);
        1: set_plane(mn, mn, mn, mx, mx, mx);
        2: set_plane(mn, 0, mx, 0, 0, 0);
        3: set_plane(0, 0, 0, 0, 0, 0);
        4, 5, 6: set_plane(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                           coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        default: set_plane(rand_coord(0), rand_coord(0), rand_coord(0),
                           rand_coord(0), rand_coord(0), rand_coord(0));
      endcase
      if (ph == 5) hold_req = 1;
      for (int r = 0; r < 85; r++)
        send_tri(rand_tri(ph < 7 ? 1'b1 : ($urandom_range(0, 3) == 0)), ROW_PREDICT);
    end

    in_ch.valid = 1'b0;
    drain();
    $display("tb: %0d triangles in, %0d triangles out, across 14 plane settings", tri_sent,
             tri_seen);
    $display("tb: covered pass, cull, one- and two-inside clips, zero and extreme planes");
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: %0d mismatches", err_count);
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== triangle_plane_clipper_core.f =====
src/tpc_pkg.sv
src/tpc_if.sv
src/tpc_front.sv
src/tpc_queue.sv
src/tpc_back.sv
src/triangle_plane_clipper_core.sv
src/tpc_checker.sv
tb/sv/tb.sv
